// ===== rtl/core/id3v2_frame_stream_parser_core_assert.svh =====
// assertion macros shared by the parser core modules
// depends on nothing; define NO_ASSERTIONS to compile them out
`ifndef ID3V2_FRAME_STREAM_PARSER_CORE_ASSERT_SVH
`define ID3V2_FRAME_STREAM_PARSER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ID3_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ID3_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ID3_ASSERT(label, clk, rst, prop, msg)
`define ID3_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/id3_pkg.sv =====
// types, codes and lookup functions of the id3v2 frame stream parser
// depends on nothing
package id3_pkg;

   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_FHDR = 3'd1,
      PH_ENC  = 3'd2,
      PH_TEXT = 3'd3,
      PH_END  = 3'd4,
      PH_NOT  = 3'd5
   } phase_type;

   localparam logic [2:0] CLS_HEADER = 3'd0;
   localparam logic [2:0] CLS_FRAME  = 3'd1;
   localparam logic [2:0] CLS_ENC    = 3'd2;
   localparam logic [2:0] CLS_TEXT   = 3'd3;
   localparam logic [2:0] CLS_PAD    = 3'd4;
   localparam logic [2:0] CLS_TRAIL  = 3'd5;
   localparam logic [2:0] CLS_NOT    = 3'd6;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_TITLE   = 3'd1;
   localparam logic [2:0] KIND_ARTIST  = 3'd2;
   localparam logic [2:0] KIND_ALBUM   = 3'd3;
   localparam logic [2:0] KIND_YEAR    = 3'd4;
   localparam logic [2:0] KIND_GENRE   = 3'd5;
   localparam logic [2:0] KIND_COMMENT = 3'd6;
   localparam logic [2:0] KIND_OTHER   = 3'd7;

   localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
   localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
   localparam logic [31:0] ID_TALB = 32'h5441_4C42;
   localparam logic [31:0] ID_TYER = 32'h5459_4552;
   localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
   localparam logic [31:0] ID_COMM = 32'h434F_4D4D;

   localparam logic [3:0] HDR_LAST_IDX   = 4'd9;
   localparam logic [3:0] FHDR_LAST_IDX  = 4'd9;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [2:0]  frame_kind;
      logic [7:0]  data_byte;
      logic [7:0]  major_version;
      logic [7:0]  revision;
      logic [28:0] tag_bytes;
      logic [30:0] frame_size;
      logic        last_of_frame;
      logic        size_error;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h49;
         2'd1:    r = 8'h44;
         default: r = 8'h33;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] classify_id(input logic [31:0] id);
      logic [2:0] r;
      case (id)
         ID_TIT2: r = KIND_TITLE;
         ID_TPE1: r = KIND_ARTIST;
         ID_TALB: r = KIND_ALBUM;
         ID_TYER: r = KIND_YEAR;
         ID_TCON: r = KIND_GENRE;
         ID_COMM: r = KIND_COMMENT;
         default: r = KIND_OTHER;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/id3_if.sv =====
// byte request and result channels of the parser core
// depends on nothing
interface id3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source (output valid, output data_byte, output start_of_file, input ready);
   modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface id3_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  byte_class;
   logic [2:0]  frame_kind;
   logic [7:0]  text_byte;
   logic [7:0]  major_version;
   logic [7:0]  revision;
   logic [28:0] tag_bytes;
   logic [30:0] frame_size;
   logic        last_of_frame;
   logic        size_error;

   modport source (output valid, output byte_class, output frame_kind, output text_byte,
                   output major_version, output revision, output tag_bytes,
                   output frame_size, output last_of_frame, output size_error,
                   input ready);
   modport sink   (input valid, input byte_class, input frame_kind, input text_byte,
                   input major_version, input revision, input tag_bytes,
                   input frame_size, input last_of_frame, input size_error,
                   output ready);
endinterface

// ===== rtl/core/id3_front.sv =====
// front end: accepts bytes, runs the tag and frame parse state, labels each word
// depends on id3_pkg, id3_if and the assertion macro header
`include "id3v2_frame_stream_parser_core_assert.svh"

module id3_front
   import id3_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   id3_req_if.sink       req_chan,
   input  fifo_stat_type stat,
   output logic          push,
   output rec_type       rec
);

   phase_type   phase_ff, phase_in, cur_phase;
   logic [3:0]  idx_ff, idx_in, cur_idx;
   logic [28:0] tag_ff, tag_in, cur_tag;
   logic [29:0] cons_ff, cons_in, cur_cons, cons_inc;
   logic [31:0] flen_ff, flen_in, cur_flen;
   logic [30:0] left_ff, left_in, cur_left, left_dec;
   logic [31:0] ident_ff, ident_in, cur_ident;
   logic [2:0]  kind_ff, kind_in, cur_kind;
   logic [7:0]  major_ff, major_in, cur_major;
   logic [7:0]  rev_ff, rev_in, cur_rev;
   logic [7:0]  b;
   logic        sof;
   logic        more_cur, more_inc;
   logic [2:0]  cls, kind_o;
   logic        last, err;
   logic        in_frame_word;
   logic        stay_not;

   assign b    = req_chan.data_byte;
   assign sof  = req_chan.start_of_file;
   assign req_chan.ready = !stat.full;
   assign push = req_chan.valid && !stat.full;

   // a start mark restarts the parse on this very word
   always_comb begin
      cur_phase = sof ? PH_HDR : phase_ff;
      cur_idx   = sof ? 4'd0   : idx_ff;
      cur_tag   = sof ? 29'd0  : tag_ff;
      cur_cons  = sof ? 30'd0  : cons_ff;
      cur_flen  = sof ? 32'd0  : flen_ff;
      cur_left  = sof ? 31'd0  : left_ff;
      cur_ident = sof ? 32'd0  : ident_ff;
      cur_kind  = sof ? KIND_NONE : kind_ff;
      cur_major = sof ? 8'd0   : major_ff;
      cur_rev   = sof ? 8'd0   : rev_ff;
   end

   assign cons_inc = (cur_cons == '1) ? cur_cons : cur_cons + 30'd1;
   assign more_cur = cur_cons < {1'b0, cur_tag};
   assign more_inc = cons_inc < {1'b0, cur_tag};
   assign left_dec = (cur_left != 31'd0) ? cur_left - 31'd1 : cur_left;

   always_comb begin
      phase_in = cur_phase;
      idx_in   = cur_idx;
      tag_in   = cur_tag;
      cons_in  = cur_cons;
      flen_in  = cur_flen;
      left_in  = cur_left;
      ident_in = cur_ident;
      kind_in  = cur_kind;
      major_in = cur_major;
      rev_in   = cur_rev;
      cls      = CLS_HEADER;
      kind_o   = KIND_NONE;
      last     = 1'b0;
      err      = 1'b0;
      case (cur_phase)
         PH_HDR: begin
            if (cur_idx < 4'd3 && b != sig_byte(cur_idx[1:0])) begin
               phase_in = PH_NOT;
               cls      = CLS_NOT;
            end else begin
               if (cur_idx == 4'd3) begin
                  major_in = b;
                  rev_in   = 8'd0;
               end
               if (cur_idx == 4'd4) begin
                  rev_in = b;
               end
               if (cur_idx >= 4'd6) begin
                  tag_in = {cur_tag[21:0], 7'd0} | {21'd0, b};
               end
               if (cur_idx >= HDR_LAST_IDX) begin
                  cons_in  = 30'd0;
                  idx_in   = 4'd0;
                  phase_in = (tag_in != 29'd0) ? PH_FHDR : PH_END;
               end else begin
                  idx_in = cur_idx + 4'd1;
               end
            end
         end
         PH_FHDR: begin
            cls     = CLS_FRAME;
            cons_in = cons_inc;
            if (cur_idx == 4'd0 && b == 8'd0) begin
               cls      = CLS_PAD;
               kind_in  = KIND_NONE;
               phase_in = PH_END;
            end else begin
               if (cur_idx == 4'd0) begin
                  kind_in  = KIND_NONE;
                  ident_in = {24'd0, b};
               end else if (cur_idx <= 4'd3) begin
                  ident_in = {cur_ident[23:0], b};
                  if (cur_idx == 4'd3) begin
                     kind_in = classify_id(ident_in);
                  end
               end else if (cur_idx <= 4'd7) begin
                  flen_in = (cur_idx == 4'd4) ? {24'd0, b} : {cur_flen[23:0], b};
               end
               kind_o = kind_in;
               if (cur_idx == 4'd7 && flen_in[31]) begin
                  err      = 1'b1;
                  phase_in = PH_END;
               end else if (cur_idx >= FHDR_LAST_IDX) begin
                  if (cur_flen == 32'd0) begin
                     last     = 1'b1;
                     idx_in   = 4'd0;
                     phase_in = more_inc ? PH_FHDR : PH_END;
                  end else begin
                     left_in  = cur_flen[30:0];
                     phase_in = PH_ENC;
                  end
               end else begin
                  idx_in = cur_idx + 4'd1;
               end
            end
         end
         PH_ENC, PH_TEXT: begin
            cls     = (cur_phase == PH_ENC) ? CLS_ENC : CLS_TEXT;
            kind_o  = cur_kind;
            cons_in = cons_inc;
            left_in = left_dec;
            if (left_dec == 31'd0) begin
               last     = 1'b1;
               idx_in   = 4'd0;
               phase_in = more_inc ? PH_FHDR : PH_END;
            end else begin
               phase_in = PH_TEXT;
            end
         end
         PH_END: begin
            cls     = more_cur ? CLS_PAD : CLS_TRAIL;
            cons_in = cons_inc;
         end
         default: begin
            cls = CLS_NOT;
         end
      endcase
   end

   always_comb begin
      rec.byte_class    = cls;
      rec.frame_kind    = kind_o;
      rec.data_byte     = b;
      rec.major_version = major_in;
      rec.revision      = rev_in;
      rec.tag_bytes     = tag_in;
      rec.frame_size    = flen_in[30:0];
      rec.last_of_frame = last;
      rec.size_error    = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         idx_ff   <= 4'd0;
         tag_ff   <= 29'd0;
         cons_ff  <= 30'd0;
         flen_ff  <= 32'd0;
         left_ff  <= 31'd0;
         ident_ff <= 32'd0;
         kind_ff  <= KIND_NONE;
         major_ff <= 8'd0;
         rev_ff   <= 8'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         tag_ff   <= tag_in;
         cons_ff  <= cons_in;
         flen_ff  <= flen_in;
         left_ff  <= left_in;
         ident_ff <= ident_in;
         kind_ff  <= kind_in;
         major_ff <= major_in;
         rev_ff   <= rev_in;
      end
   end

   assign in_frame_word = (cls == CLS_FRAME) || (cls == CLS_ENC) || (cls == CLS_TEXT);
   assign stay_not      = push && !sof && (phase_ff == PH_NOT);

   `ID3_ASSERT(a_kind_only_in_frame, clock, reset, (push && kind_o != KIND_NONE) |-> in_frame_word, "frame kind outside frame word")
   `ID3_ASSERT(a_not_id3_sticks, clock, reset, stay_not |=> phase_ff == PH_NOT, "not-id3 state left")

endmodule

// ===== rtl/core/id3_queue.sv =====
// short queue of labelled words between the front and back ends
// depends on id3_pkg and the assertion macro header
`include "id3v2_frame_stream_parser_core_assert.svh"

module id3_queue
   import id3_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rec_type       wr_rec,
   input  logic          pop,
   output rec_type       rd_rec,
   output fifo_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rec_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rd_rec     = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= wr_rec;
      end
   end

   `ID3_ASSERT(a_no_overflow, clock, reset, push |-> !stat.full, "push into full queue")
   `ID3_ASSERT(a_no_underflow, clock, reset, pop |-> !stat.empty, "pop from empty queue")
   `ID3_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/core/id3_back.sv =====
// back end: drains the queue into the result register and formats the word
// depends on id3_pkg and id3_if
module id3_back
   import id3_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rec_type       rd_rec,
   input  fifo_stat_type stat,
   output logic          pop,
   id3_rsp_if.source     rsp_chan
);

   logic       valid_ff, valid_in;
   rec_type    out_ff, out_in;
   logic       is_content;

   assign pop = !stat.empty && (!valid_ff || rsp_chan.ready);
   assign is_content = rd_rec.byte_class inside {CLS_ENC, CLS_TEXT};

   always_comb begin
      out_in           = rd_rec;
      out_in.data_byte = is_content ? rd_rec.data_byte : 8'd0;
      valid_in         = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.byte_class    = out_ff.byte_class;
   assign rsp_chan.frame_kind    = out_ff.frame_kind;
   assign rsp_chan.text_byte     = out_ff.data_byte;
   assign rsp_chan.major_version = out_ff.major_version;
   assign rsp_chan.revision      = out_ff.revision;
   assign rsp_chan.tag_bytes     = out_ff.tag_bytes;
   assign rsp_chan.frame_size    = out_ff.frame_size;
   assign rsp_chan.last_of_frame = out_ff.last_of_frame;
   assign rsp_chan.size_error    = out_ff.size_error;

endmodule

// ===== rtl/core/id3v2_frame_stream_parser_core.sv =====
// top level of the id3v2 frame stream parser core
// depends on id3_pkg, id3_if, id3_front, id3_queue and id3_back
//
// One result word leaves for every byte taken in, in order, and the core
// sustains one byte per clock while the queue is not full. A byte accepted
// is written into the queue, moves on into the result register when the
// back end pops it and is offered from there until taken. The front end
// holds the whole parse state and updates it in the cycle the byte is
// accepted; the queue of QUEUE_DEPTH words plus the result register lets
// input keep flowing while the result side stalls. start_of_file on a
// byte restarts the parse with that byte as the first header byte.
module id3v2_frame_stream_parser_core
   import id3_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   id3_req_if.sink   req_chan,
   id3_rsp_if.source rsp_chan
);

   fifo_stat_type stat;
   rec_type       wr_rec, rd_rec;
   logic          push, pop;

   id3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .stat     (stat),
      .push     (push),
      .rec      (wr_rec)
   );

   id3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_rec (wr_rec),
      .pop    (pop),
      .rd_rec (rd_rec),
      .stat   (stat)
   );

   id3_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rd_rec   (rd_rec),
      .stat     (stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/id3v2_frame_stream_parser_core_test.sv =====
// testbench of the id3v2 frame stream parser core: byte streams of tags, frames and noise
// checked word by word against a parse predictor kept in step with every accepted byte
// depends on id3_pkg, id3_if and id3v2_frame_stream_parser_core
module id3v2_frame_stream_parser_core_test
   import id3_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_BYTES   = 1150;
   localparam int PRINT_LIMIT    = 50;

   localparam logic [23:0] ID3_SIGNATURE = "ID3";

   typedef logic [7:0] byte_list [$];

   typedef enum int {
      FLOW_OPEN,
      FLOW_LIGHT,
      FLOW_HEAVY
   } flow_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   id3_req_if req_chan ();
   id3_rsp_if rsp_chan ();

   id3v2_frame_stream_parser_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // parse state of the predictor
   phase_type   ps_phase;
   logic [3:0]  ps_index;
   logic [28:0] ps_tag_len;
   logic [31:0] ps_consumed;
   logic [31:0] ps_frame_len;
   logic [31:0] ps_content_left;
   logic [31:0] ps_frame_code;
   logic [2:0]  ps_kind;
   logic [7:0]  ps_major;
   logic [7:0]  ps_rev;

   rec_type expected_words [$];

   int mismatch_count = 0;
   int words_checked  = 0;
   int bytes_sent     = 0;
   int burst_left     = 0;
   bit gapless        = 1'b0;
   int hold_asked     = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int flow_run       = 0;
   int idle_cycles    = 0;
   flow_mode_type flow_mode = FLOW_OPEN;

   function automatic void parse_restart();
      ps_phase        = PH_HDR;
      ps_index        = '0;
      ps_tag_len      = '0;
      ps_consumed     = '0;
      ps_frame_len    = '0;
      ps_content_left = '0;
      ps_frame_code   = '0;
      ps_kind         = KIND_NONE;
      ps_major        = '0;
      ps_rev          = '0;
   endfunction

   function automatic void count_consumed();
      if (ps_consumed != '1) begin
         ps_consumed++;
      end
   endfunction

   function automatic void begin_next_frame();
      ps_index = '0;
      ps_phase = (ps_consumed < ps_tag_len) ? PH_FHDR : PH_END;
   endfunction

   function automatic rec_type parse_byte(input logic [7:0] b, input logic sof);
      rec_type r;
      r = '0;
      if (sof) begin
         parse_restart();
      end
      case (ps_phase)
         PH_HDR: begin
            if (ps_index < 3 && b != ID3_SIGNATURE[23 - 8 * int'(ps_index) -: 8]) begin
               r.byte_class = CLS_NOT;
               ps_phase     = PH_NOT;
            end else begin
               r.byte_class = CLS_HEADER;
               case (ps_index)
                  4'd3: begin
                     ps_major = b;
                     ps_rev   = '0;
                  end
                  4'd4: ps_rev = b;
                  4'd6, 4'd7, 4'd8, 4'd9: ps_tag_len = {ps_tag_len[21:0], 7'b0} | 29'(b);
                  default: ;
               endcase
               if (ps_index >= HDR_LAST_IDX) begin
                  ps_consumed = '0;
                  begin_next_frame();
               end else begin
                  ps_index++;
               end
            end
         end
         PH_FHDR: begin
            r.byte_class = CLS_FRAME;
            count_consumed();
            if (ps_index == 0 && b == 8'h00) begin
               // zero id byte closes the tag
               r.byte_class = CLS_PAD;
               ps_kind      = KIND_NONE;
               ps_phase     = PH_END;
            end else begin
               case (ps_index)
                  4'd0: begin
                     ps_kind       = KIND_NONE;
                     ps_frame_code = 32'(b);
                  end
                  4'd1, 4'd2: ps_frame_code = {ps_frame_code[23:0], b};
                  4'd3: begin
                     ps_frame_code = {ps_frame_code[23:0], b};
                     case (ps_frame_code)
                        ID_TIT2: ps_kind = KIND_TITLE;
                        ID_TPE1: ps_kind = KIND_ARTIST;
                        ID_TALB: ps_kind = KIND_ALBUM;
                        ID_TYER: ps_kind = KIND_YEAR;
                        ID_TCON: ps_kind = KIND_GENRE;
                        ID_COMM: ps_kind = KIND_COMMENT;
                        default: ps_kind = KIND_OTHER;
                     endcase
                  end
                  4'd4: ps_frame_len = 32'(b);
                  4'd5, 4'd6, 4'd7: ps_frame_len = {ps_frame_len[23:0], b};
                  default: ;
               endcase
               r.frame_kind = ps_kind;
               if (ps_index == 7 && ps_frame_len[31]) begin
                  r.size_error = 1'b1;
                  ps_phase     = PH_END;
               end else if (ps_index >= FHDR_LAST_IDX) begin
                  if (ps_frame_len == 0) begin
                     r.last_of_frame = 1'b1;
                     begin_next_frame();
                  end else begin
                     ps_content_left = ps_frame_len;
                     ps_phase        = PH_ENC;
                  end
               end else begin
                  ps_index++;
               end
            end
         end
         PH_ENC, PH_TEXT: begin
            r.byte_class = (ps_phase == PH_ENC) ? CLS_ENC : CLS_TEXT;
            r.frame_kind = ps_kind;
            r.data_byte  = b;
            count_consumed();
            if (ps_content_left != 0) begin
               ps_content_left--;
            end
            if (ps_content_left == 0) begin
               r.last_of_frame = 1'b1;
               begin_next_frame();
            end else begin
               ps_phase = PH_TEXT;
            end
         end
         PH_END: begin
            r.byte_class = (ps_consumed < ps_tag_len) ? CLS_PAD : CLS_TRAIL;
            count_consumed();
         end
         default: r.byte_class = CLS_NOT;
      endcase
      r.major_version = ps_major;
      r.revision      = ps_rev;
      r.tag_bytes     = ps_tag_len;
      r.frame_size    = ps_frame_len[30:0];
      return r;
   endfunction

   function automatic logic [31:0] synchsafe(input int unsigned t);
      logic [27:0] v;
      v = t[27:0];
      return {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]};
   endfunction

   function automatic void add_header(ref byte_list q, input logic [7:0] ver,
                                      input logic [7:0] rev, input logic [31:0] size_field);
      for (int i = 2; i >= 0; i--) begin
         q.push_back(ID3_SIGNATURE[8 * i +: 8]);
      end
      q.push_back(ver);
      q.push_back(rev);
      q.push_back(8'($urandom));
      for (int i = 3; i >= 0; i--) begin
         q.push_back(size_field[8 * i +: 8]);
      end
   endfunction

   function automatic void add_frame(ref byte_list q, input logic [31:0] id,
                                     input logic [31:0] len, input int body);
      for (int i = 3; i >= 0; i--) begin
         q.push_back(id[8 * i +: 8]);
      end
      for (int i = 3; i >= 0; i--) begin
         q.push_back(len[8 * i +: 8]);
      end
      repeat (2 + body) q.push_back(8'($urandom));
   endfunction

   function automatic void build_random_file(ref byte_list q);
      int          pick;
      int          prefix;
      int          tag_goal;
      int          used;
      int          pad;
      int          cut;
      logic [31:0] size_field;
      logic [31:0] frame_len;
      logic [31:0] frame_code;
      bit          done;
      q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // noise: part of the signature then random bytes
         prefix = $urandom_range(0, 2);
         for (int i = 0; i < prefix; i++) begin
            q.push_back(ID3_SIGNATURE[23 - 8 * i -: 8]);
         end
         repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
      end else begin
         tag_goal   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 120);
         size_field = synchsafe(tag_goal);
         if ($urandom_range(0, 7) == 0) begin
            size_field = $urandom;
            tag_goal   = 150;
         end
         add_header(q, 8'($urandom), 8'($urandom), size_field);
         used = 0;
         done = 1'b0;
         while (!done && used < tag_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               q.push_back(8'h00);
               pad = tag_goal - used - 1;
               if (pad > 40) begin
                  pad = 40;
               end
               if (pad > 0) begin
                  repeat (pad) q.push_back(8'h00);
               end
               done = 1'b1;
            end else if (pick < 11) begin
               // size with any bits, often the error bit: file stops early
               frame_len = $urandom;
               add_frame(q, {8'($urandom_range(1, 255)), 24'($urandom)}, frame_len,
                         $urandom_range(0, 6));
               done = 1'b1;
            end else begin
               frame_len = $urandom_range(0, 12);
               case ($urandom_range(0, 6))
                  0:       frame_code = ID_TIT2;
                  1:       frame_code = ID_TPE1;
                  2:       frame_code = ID_TALB;
                  3:       frame_code = ID_TYER;
                  4:       frame_code = ID_TCON;
                  5:       frame_code = ID_COMM;
                  default: frame_code = {8'($urandom_range(1, 255)), 24'($urandom)};
               endcase
               add_frame(q, frame_code, frame_len, int'(frame_len));
               used += 10 + int'(frame_len);
            end
         end
         repeat ($urandom_range(0, 4)) q.push_back(8'($urandom));
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, q.size());
            while (q.size() > cut) begin
               void'(q.pop_back());
            end
         end
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic sof);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= b;
      req_chan.start_of_file <= sof;
      do @(posedge clock); while (!req_chan.ready);
      expected_words.push_back(parse_byte(b, sof));
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_file(input byte_list q, input bit mark_start);
      foreach (q[i]) begin
         send_byte(q[i], mark_start && i == 0);
      end
   endtask

   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t word %0d: %s got %0h expected %0h", $realtime, words_checked, what,
                  got, want);
      end
   endtask

   // empty tag reached without a start mark right after reset
   task automatic test_no_start_mark();
      byte_list q;
      add_header(q, 8'h00, 8'hFF, 32'h0);
      q.push_back(8'hFF);
      q.push_back(8'h00);
      send_file(q, 1'b0);
   endtask

   task automatic test_bad_signature();
      byte_list q;
      q = '{8'h49, 8'h44, 8'h32, 8'hAA};
      send_file(q, 1'b1);
      q = '{8'h00, 8'h49};
      send_file(q, 1'b1);
   endtask

   // frames, zero size frame, zero id byte, padding then trailing data
   task automatic test_frames_and_padding();
      byte_list q;
      add_header(q, 8'h03, 8'h00, synchsafe(26));
      add_frame(q, ID_TIT2, 32'd2, 2);
      add_frame(q, ID_TPE1, 32'd0, 0);
      q.push_back(8'h00);
      repeat (5) q.push_back(8'($urandom));
      send_file(q, 1'b1);
   endtask

   task automatic test_size_error();
      byte_list q;
      add_header(q, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      add_frame(q, ID_TCON, 32'h8000_0000, 0);
      send_file(q, 1'b1);
   endtask

   task automatic test_long_frames();
      byte_list q;
      add_header(q, 8'h04, 8'h01, synchsafe(4));
      add_frame(q, ID_TYER, 32'd6, 6);
      q.push_back(8'h5A);
      send_file(q, 1'b1);
      q.delete();
      add_header(q, 8'h04, 8'h00, synchsafe(200));
      add_frame(q, ID_COMM, 32'h7FFF_FFFF, 3);
      send_file(q, 1'b1);
   endtask

   // result side holds off while bytes keep coming
   task automatic test_receiver_hold();
      byte_list q;
      gapless = 1'b1;
      hold_asked++;
      add_header(q, 8'h03, 8'h00, synchsafe(30));
      add_frame(q, ID_TALB, 32'd20, 20);
      repeat (4) q.push_back(8'h00);
      send_file(q, 1'b1);
      gapless = 1'b0;
   endtask

   task automatic test_sender_pause();
      byte_list q;
      build_random_file(q);
      send_file(q, 1'b1);
      pause_until_drained();
      build_random_file(q);
      send_file(q, 1'b1);
   endtask

   task automatic test_random_files();
      byte_list q;
      int       stop_at;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) begin
         build_random_file(q);
         send_file(q, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (flow_run == 0) begin
               flow_run  = $urandom_range(1, 60);
               flow_mode = flow_mode_type'($urandom_range(0, 2));
            end
            flow_run--;
            case (flow_mode)
               FLOW_OPEN:  rsp_chan.ready <= 1'b1;
               FLOW_LIGHT: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default:    rsp_chan.ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rec_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            report("word with nothing expected", 32'h0, 32'h0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_chan.byte_class !== want.byte_class)
               report("byte_class", 32'(rsp_chan.byte_class), 32'(want.byte_class));
            if (rsp_chan.frame_kind !== want.frame_kind)
               report("frame_kind", 32'(rsp_chan.frame_kind), 32'(want.frame_kind));
            if (rsp_chan.text_byte !== want.data_byte)
               report("text_byte", 32'(rsp_chan.text_byte), 32'(want.data_byte));
            if (rsp_chan.major_version !== want.major_version)
               report("major_version", 32'(rsp_chan.major_version), 32'(want.major_version));
            if (rsp_chan.revision !== want.revision)
               report("revision", 32'(rsp_chan.revision), 32'(want.revision));
            if (rsp_chan.tag_bytes !== want.tag_bytes)
               report("tag_bytes", 32'(rsp_chan.tag_bytes), 32'(want.tag_bytes));
            if (rsp_chan.frame_size !== want.frame_size)
               report("frame_size", 32'(rsp_chan.frame_size), 32'(want.frame_size));
            if (rsp_chan.last_of_frame !== want.last_of_frame)
               report("last_of_frame", 32'(rsp_chan.last_of_frame), 32'(want.last_of_frame));
            if (rsp_chan.size_error !== want.size_error)
               report("size_error", 32'(rsp_chan.size_error), 32'(want.size_error));
         end
         words_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid         <= 1'b0;
      req_chan.data_byte     <= 8'h00;
      req_chan.start_of_file <= 1'b0;
      parse_restart();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_no_start_mark();
      test_bad_signature();
      test_frames_and_padding();
      test_size_error();
      test_long_frames();
      test_receiver_hold();
      test_sender_pause();
      test_random_files();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
